### src/bllca_pkg.sv
// shared types, sizes and address helpers for the binary lifting lca engine
// no dependencies
`default_nettype none

package bllca_pkg;

    localparam int NODES     = 1024;
    localparam int LEVELS    = 10;
    localparam int NODE_W    = 10;
    localparam int DEP_W     = 10;
    localparam int NODE_AW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_AW    = NODE_AW + LVL_W;
    localparam int ANC_DEPTH = NODES << LVL_W;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [NODE_AW-1:0] t_naddr;
    typedef logic [LVL_W-1:0]   t_lvl;
    typedef logic [ANC_AW-1:0]  t_anc_addr;
    typedef logic [DEP_W-1:0]   t_dep;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam t_lvl LVL_LAST = t_lvl'(LEVELS - 1);

    typedef struct packed {
        logic      command;
        t_node     first_node;
        t_node     second_node;
    } t_item;

    // read and write requests from the sequencer to the tables
    typedef struct packed {
        t_naddr    dep_raddr;
        logic      dep_we;
        t_naddr    dep_waddr;
        t_dep      dep_wdata;
        t_anc_addr anc_raddr;
        logic      anc_we;
        t_anc_addr anc_waddr;
        t_node     anc_wdata;
    } t_mem_req;

    typedef struct packed {
        logic      clearing;
        t_dep      dep_rdata;
        t_node     anc_rdata;
    } t_mem_rsp;

    // out-of-range nodes act as node zero
    function automatic t_node node_index(input t_node raw);
        return (32'(raw) < NODES) ? raw : '0;
    endfunction

    function automatic t_naddr node_addr(input t_node n);
        return t_naddr'(n);
    endfunction

    function automatic t_anc_addr anc_addr(input t_node n, input t_lvl l);
        return {node_addr(n), l};
    endfunction

endpackage

`default_nettype wire

### src/bllca_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bllca_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/bllca_store.sv
// depth and ancestor tables: two rams, clearing sweep after reset, write forwarding
// depends on bllca_pkg and bllca_ram
`default_nettype none

module bllca_store (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bllca_pkg::t_mem_req i_req,
    output bllca_pkg::t_mem_rsp      o_rsp
);
    import bllca_pkg::*;

    logic      r_clearing;
    t_anc_addr r_clr_addr;

    logic      anc_we, dep_we;
    t_anc_addr anc_waddr;
    t_naddr    dep_waddr;
    t_node     anc_wdata, anc_q;
    t_dep      dep_wdata, dep_q;

    logic      r_anc_hit, r_dep_hit;
    t_node     r_anc_fwd;
    t_dep      r_dep_fwd;

    // sweep every ancestor row once, depth entries ride along on the low bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (32'(r_clr_addr) == ANC_DEPTH - 1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clearing) begin
            anc_we    = 1'b1;
            anc_waddr = r_clr_addr;
            anc_wdata = '0;
            dep_we    = 1'b1;
            dep_waddr = t_naddr'(r_clr_addr);
            dep_wdata = '0;
        end else begin
            anc_we    = i_req.anc_we;
            anc_waddr = i_req.anc_waddr;
            anc_wdata = i_req.anc_wdata;
            dep_we    = i_req.dep_we;
            dep_waddr = i_req.dep_waddr;
            dep_wdata = i_req.dep_wdata;
        end
    end

    bllca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH), .AW(ANC_AW)) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (anc_waddr),
        .i_wdata (anc_wdata),
        .i_raddr (i_req.anc_raddr),
        .o_rdata (anc_q)
    );

    bllca_ram #(.WIDTH(DEP_W), .DEPTH(NODES), .AW(NODE_AW)) u_dep_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (i_req.dep_raddr),
        .o_rdata (dep_q)
    );

    // same-cycle read of the entry being written returns the new value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anc_hit <= 1'b0;
            r_dep_hit <= 1'b0;
        end else begin
            r_anc_hit <= anc_we && (anc_waddr == i_req.anc_raddr);
            r_dep_hit <= dep_we && (dep_waddr == i_req.dep_raddr);
        end
        r_anc_fwd <= anc_wdata;
        r_dep_fwd <= dep_wdata;
    end

    assign o_rsp.clearing  = r_clearing;
    assign o_rsp.anc_rdata = r_anc_hit ? r_anc_fwd : anc_q;
    assign o_rsp.dep_rdata = r_dep_hit ? r_dep_fwd : dep_q;

endmodule

`default_nettype wire

### src/bllca_seq.sv
// sequencer for node loads and lca queries over the table store
// depends on bllca_pkg
`default_nettype none

module bllca_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire bllca_pkg::t_item    i_item,
    output logic                    o_ready,
    output logic                    o_res_valid,
    output bllca_pkg::t_node         o_res,
    input  wire logic               i_res_ready,
    output bllca_pkg::t_mem_req      o_req,
    input  wire bllca_pkg::t_mem_rsp i_rsp
);
    import bllca_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LD_W0 = 4'd1;
    localparam logic [3:0] S_LD_LV = 4'd2;
    localparam logic [3:0] S_Q_DB  = 4'd3;
    localparam logic [3:0] S_Q_SW  = 4'd4;
    localparam logic [3:0] S_Q_L   = 4'd5;
    localparam logic [3:0] S_Q_LW  = 4'd6;
    localparam logic [3:0] S_Q_EQ  = 4'd7;
    localparam logic [3:0] S_Q_RA  = 4'd8;
    localparam logic [3:0] S_Q_RB  = 4'd9;
    localparam logic [3:0] S_Q_CMP = 4'd10;
    localparam logic [3:0] S_Q_FIN = 4'd11;
    localparam logic [3:0] S_PUT   = 4'd12;

    logic [3:0] r_state, n_state;
    t_lvl       r_lvl, n_lvl;
    t_node      r_a, n_a;
    t_node      r_b, n_b;
    t_node      r_qa, n_qa;
    t_dep       r_da, n_da;
    t_dep       r_gap, n_gap;

    logic       accept;
    t_node      in_a, in_b, nv_a, nv_b;
    t_dep       dq;
    t_node      aq;

    assign accept = i_valid && o_ready;
    assign in_a   = node_index(i_item.first_node);
    assign in_b   = node_index(i_item.second_node);
    assign dq     = i_rsp.dep_rdata;
    assign aq     = i_rsp.anc_rdata;
    assign nv_a   = (r_qa != aq) ? r_qa : r_a;
    assign nv_b   = (r_qa != aq) ? aq : r_b;

    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        n_a     = r_a;
        n_b     = r_b;
        n_qa    = r_qa;
        n_da    = r_da;
        n_gap   = r_gap;
        o_req   = '0;
        o_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = !i_rsp.clearing;
                if (i_item.command == CMD_LOAD) begin
                    o_req.dep_raddr = node_addr(in_b);
                end else begin
                    o_req.dep_raddr = node_addr(in_a);
                end
                if (accept) begin
                    n_a = in_a;
                    n_b = in_b;
                    if (i_item.command == CMD_QUERY) begin
                        n_state = S_Q_DB;
                    end else if (in_a != '0) begin
                        n_state = S_LD_W0;
                    end
                end
            end
            S_LD_W0: begin
                // depth of parent plus one, saturating
                o_req.dep_we    = 1'b1;
                o_req.dep_waddr = node_addr(r_a);
                o_req.dep_wdata = (dq == '1) ? dq : dq + 1'b1;
                o_req.anc_we    = 1'b1;
                o_req.anc_waddr = anc_addr(r_a, '0);
                o_req.anc_wdata = r_b;
                o_req.anc_raddr = anc_addr(r_b, '0);
                n_lvl           = t_lvl'(1);
                n_state         = (LEVELS == 1) ? S_IDLE : S_LD_LV;
            end
            S_LD_LV: begin
                o_req.anc_we    = 1'b1;
                o_req.anc_waddr = anc_addr(r_a, r_lvl);
                o_req.anc_wdata = aq;
                o_req.anc_raddr = anc_addr(aq, r_lvl);
                if (r_lvl == LVL_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_lvl = r_lvl + 1'b1;
                end
            end
            S_Q_DB: begin
                n_da            = dq;
                o_req.dep_raddr = node_addr(r_b);
                n_state         = S_Q_SW;
            end
            S_Q_SW: begin
                // deeper node goes to a
                if (r_da < dq) begin
                    n_a   = r_b;
                    n_b   = r_a;
                    n_gap = dq - r_da;
                end else begin
                    n_gap = r_da - dq;
                end
                n_lvl   = '0;
                n_state = S_Q_L;
            end
            S_Q_L: begin
                o_req.anc_raddr = anc_addr(r_a, r_lvl);
                if (r_gap[0]) begin
                    n_state = S_Q_LW;
                end else begin
                    n_gap = r_gap >> 1;
                    if (r_lvl == LVL_LAST) begin
                        n_state = S_Q_EQ;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end
            end
            S_Q_LW: begin
                n_a   = aq;
                n_gap = r_gap >> 1;
                if (r_lvl == LVL_LAST) begin
                    n_state = S_Q_EQ;
                end else begin
                    n_lvl   = r_lvl + 1'b1;
                    n_state = S_Q_L;
                end
            end
            S_Q_EQ: begin
                n_lvl   = LVL_LAST;
                n_state = (r_a == r_b) ? S_PUT : S_Q_RA;
            end
            S_Q_RA: begin
                o_req.anc_raddr = anc_addr(r_a, r_lvl);
                n_state         = S_Q_RB;
            end
            S_Q_RB: begin
                n_qa            = aq;
                o_req.anc_raddr = anc_addr(r_b, r_lvl);
                n_state         = S_Q_CMP;
            end
            S_Q_CMP: begin
                // lift both while the ancestors differ
                n_a = nv_a;
                n_b = nv_b;
                if (r_lvl == '0) begin
                    o_req.anc_raddr = anc_addr(nv_a, '0);
                    n_state         = S_Q_FIN;
                end else begin
                    o_req.anc_raddr = anc_addr(nv_a, r_lvl - 1'b1);
                    n_lvl           = r_lvl - 1'b1;
                    n_state         = S_Q_RB;
                end
            end
            S_Q_FIN: begin
                n_a     = aq;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lvl <= n_lvl;
        r_a   <= n_a;
        r_b   <= n_b;
        r_qa  <= n_qa;
        r_da  <= n_da;
        r_gap <= n_gap;
    end

    assign o_res_valid = (r_state == S_PUT);
    assign o_res       = r_a;

endmodule

`default_nettype wire

### src/binary_lifting_lca_engine_top.sv
// top level of the binary lifting lca engine: sequencer, table store, output register
// depends on bllca_pkg, bllca_store, bllca_seq
//
// channel   handshake            payload
// -------   ------------------   ----------------------------------------------
// input     i_valid / o_ready    i_command, i_first_node, i_second_node
// output    o_valid / i_ready    o_common_ancestor (one item per query)
//
// a load writes the depth and level-zero ancestor, then each higher level in
// turn, one table read per ancestor level; a query reads both depths, lifts the
// deeper node to equal depth, then lifts both from the top level down while the
// ancestors differ (skipped if both already meet), one read at a time on the
// single read port of the ancestor ram; after reset a clearing pass over all
// ANC_DEPTH rows (16384 as built) zeroes both tables, o_ready held low meanwhile
// a finished result waits in the output register; the next item is taken
// while it waits, and a second result stalls only until the first is taken
`default_nettype none

module binary_lifting_lca_engine_top (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_command,
    input  wire bllca_pkg::t_node        i_first_node,
    input  wire bllca_pkg::t_node        i_second_node,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output bllca_pkg::t_node             o_common_ancestor
);
    import bllca_pkg::*;

    t_item    item;
    t_mem_req req;
    t_mem_rsp rsp;
    logic     res_valid, res_ready;
    t_node    res;

    logic     r_ov;
    t_node    r_res;

    assign item.command     = i_command;
    assign item.first_node  = i_first_node;
    assign item.second_node = i_second_node;

    // output slot is free when empty or being drained this cycle
    assign res_ready = !r_ov || i_ready;

    bllca_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (item),
        .o_ready     (o_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_req       (req),
        .i_rsp       (rsp)
    );

    bllca_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (res_ready) begin
            r_ov <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid           = r_ov;
    assign o_common_ancestor = r_res;

endmodule

`default_nettype wire
